@@ rtl/rpb_pkg.sv @@
// ----------------------------------------------------------------------------
// rpb_pkg: shared types and constants of the Potts row-pair bond counter
// Register indexes, fixed field widths and the decoded configuration.
// ----------------------------------------------------------------------------
package rpb_pkg;

	// packed row word
	localparam int ROW_BITS = 64;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SITE_COUNT  = 2'd0,
		REG_STATE_COUNT = 2'd1,
		REG_CYCLIC_ROWS = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	// result field widths
	localparam int BOND_W = 6;
	localparam int ZERO_W = 5;

	// internal sums: at most 2 * 64 pairs
	localparam int SUM_W = 8;

	// decoded configuration, sized for the widest parameter setting
	typedef struct packed {
		logic [6:0] site_n;  // sites in use, 2..64
		logic [4:0] state_q; // clamped spin state count
		logic [3:0] field_w; // bits per site field
		logic       cyclic;  // count the wrap bond
	} cfg_t;

	// bits per field for a clamped state count
	function automatic logic [3:0] field_width(input logic [4:0] q);
		logic [3:0] w;
		if (q <= 5'd2) begin
			w = 4'd1;
		end else if (q <= 5'd4) begin
			w = 4'd2;
		end else if (q <= 5'd8) begin
			w = 4'd3;
		end else if (q <= 5'd16) begin
			w = 4'd4;
		end else begin
			w = 4'd5;
		end
		return w;
	endfunction

	// how many fields of a width fit in one row word
	function automatic logic [6:0] sites_fit(input logic [3:0] w);
		logic [6:0] n;
		case (w)
			4'd1:    n = 7'd64;
			4'd2:    n = 7'd32;
			4'd3:    n = 7'd21;
			4'd4:    n = 7'd16;
			4'd5:    n = 7'd12;
			4'd6:    n = 7'd10;
			4'd7:    n = 7'd9;
			default: n = 7'd8;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/rpb_cfg.sv @@
// ----------------------------------------------------------------------------
// rpb_cfg: configuration registers and decode
// Holds the three registers and clamps them into the working row geometry.
// ----------------------------------------------------------------------------
module rpb_cfg #(
	parameter int SITES_MAX      = 16,
	parameter int FIELD_BITS_MAX = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rpb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rpb_pkg::cfg_t                   cfg
);
	import rpb_pkg::*;

	localparam int QMAX = 1 << FIELD_BITS_MAX;

	logic [4:0] site_count_q;
	logic [4:0] state_count_q;
	logic       cyclic_rows_q;

	logic [4:0] q_clamped;
	logic [3:0] w;
	logic [6:0] n_raw;
	logic [6:0] n_fit;
	logic [6:0] n_lim;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q  <= 5'd16;
			state_count_q <= 5'd2;
			cyclic_rows_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SITE_COUNT:  site_count_q  <= cfg_data[4:0];
				REG_STATE_COUNT: state_count_q <= cfg_data[4:0];
				REG_CYCLIC_ROWS: cyclic_rows_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp Q, derive field width, clamp N to parameter and word size
	always_comb begin
		q_clamped = state_count_q;
		if (q_clamped < 5'd2) begin
			q_clamped = 5'd2;
		end
		if (32'(q_clamped) > QMAX) begin
			q_clamped = 5'(QMAX);
		end
		w = field_width(q_clamped);

		n_raw = {2'b00, site_count_q};
		if (n_raw < 7'd2) begin
			n_raw = 7'd2;
		end
		n_lim = n_raw;
		if (32'(n_lim) > SITES_MAX) begin
			n_lim = 7'(SITES_MAX);
		end
		n_fit = sites_fit(w);
		if (n_lim > n_fit) begin
			n_lim = n_fit;
		end

		cfg.site_n  = n_lim;
		cfg.state_q = q_clamped;
		cfg.field_w = w;
		cfg.cyclic  = cyclic_rows_q;
	end

endmodule

@@ rtl/rpb_site.sv @@
// ----------------------------------------------------------------------------
// rpb_site: input register and per-site compare stage
// Unpacks both rows and registers per-site match, zero and range flags.
// ----------------------------------------------------------------------------
module rpb_site #(
	parameter int SITES_MAX      = 16,
	parameter int FIELD_BITS_MAX = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  logic [rpb_pkg::ROW_BITS-1:0]   row_now,
	input  logic [rpb_pkg::ROW_BITS-1:0]   row_next,
	input  rpb_pkg::cfg_t                  cfg,
	output logic                           valid_s2,
	output logic                           pair_ok_s2,
	output logic [SITES_MAX-1:0]           horiz_eq_s2,
	output logic [SITES_MAX-1:0]           vert_eq_s2,
	output logic [SITES_MAX-1:0]           zero_s2
);
	import rpb_pkg::*;

	typedef logic [FIELD_BITS_MAX-1:0] field_t;

	logic                valid_s1;
	logic [ROW_BITS-1:0] row_now_s1;
	logic [ROW_BITS-1:0] row_next_s1;

	field_t              fa [SITES_MAX];
	field_t              fb [SITES_MAX];
	logic [SITES_MAX-1:0] used;
	logic                pair_ok;
	logic [SITES_MAX-1:0] horiz_eq;
	logic [SITES_MAX-1:0] vert_eq;
	logic [SITES_MAX-1:0] zero_hit;
	field_t              f_last;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			row_now_s1  <= row_now;
			row_next_s1 <= row_next;
		end
	end

	// field unpack: select the slice for the active field width
	always_comb begin
		for (int i = 0; i < SITES_MAX; i++) begin
			fa[i] = '0;
			fb[i] = '0;
			for (int wv = 1; wv <= FIELD_BITS_MAX; wv++) begin
				if ((32'(cfg.field_w) == wv) && ((i + 1) * wv <= ROW_BITS)) begin
					fa[i] = FIELD_BITS_MAX'((row_now_s1 >> (i * wv)) &
						((64'd1 << wv) - 64'd1));
					fb[i] = FIELD_BITS_MAX'((row_next_s1 >> (i * wv)) &
						((64'd1 << wv) - 64'd1));
				end
			end
		end
	end

	// per-site flags
	always_comb begin
		f_last  = fa[0];
		pair_ok = 1'b1;
		for (int i = 0; i < SITES_MAX; i++) begin
			used[i] = 32'(cfg.site_n) > i;
			if (32'(cfg.site_n) == i + 1) begin
				f_last = fa[i];
			end
			if (used[i] && ((32'(fa[i]) >= 32'(cfg.state_q)) ||
				(32'(fb[i]) >= 32'(cfg.state_q)))) begin
				pair_ok = 1'b0;
			end
			vert_eq[i]  = used[i] && (fa[i] == fb[i]);
			zero_hit[i] = used[i] && (fa[i] == '0);
		end
		// bit 0 carries the wrap bond, bit i the bond between i-1 and i
		horiz_eq[0] = cfg.cyclic && (fa[0] == f_last);
		for (int i = 1; i < SITES_MAX; i++) begin
			horiz_eq[i] = used[i] && (fa[i] == fa[i-1]);
		end
	end

	// compare stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			pair_ok_s2  <= pair_ok;
			horiz_eq_s2 <= horiz_eq;
			vert_eq_s2  <= vert_eq;
			zero_s2     <= zero_hit;
		end
	end

endmodule

@@ rtl/rpb_count.sv @@
// ----------------------------------------------------------------------------
// rpb_count: flag counting and result register
// Counts bond and zero flags, saturates, and holds the result item.
// ----------------------------------------------------------------------------
module rpb_count #(
	parameter int SITES_MAX = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         valid_s2,
	input  logic                         pair_ok_s2,
	input  logic [SITES_MAX-1:0]         horiz_eq_s2,
	input  logic [SITES_MAX-1:0]         vert_eq_s2,
	input  logic [SITES_MAX-1:0]         zero_s2,
	output logic                         out_valid,
	output logic                         pair_valid,
	output logic [rpb_pkg::BOND_W-1:0]   bond_count,
	output logic [rpb_pkg::ZERO_W-1:0]   zero_spin_count
);
	import rpb_pkg::*;

	logic [SUM_W-1:0]  bond_sum;
	logic [SUM_W-1:0]  zero_sum;
	logic [BOND_W-1:0] bond_sat;
	logic [ZERO_W-1:0] zero_sat;

	// popcounts, zeroed for an out-of-range pair
	always_comb begin
		bond_sum = '0;
		zero_sum = '0;
		for (int i = 0; i < SITES_MAX; i++) begin
			bond_sum = bond_sum + SUM_W'(horiz_eq_s2[i]) + SUM_W'(vert_eq_s2[i]);
			zero_sum = zero_sum + SUM_W'(zero_s2[i]);
		end
		if (!pair_ok_s2) begin
			bond_sum = '0;
			zero_sum = '0;
		end
		bond_sat = (bond_sum > SUM_W'({BOND_W{1'b1}})) ? {BOND_W{1'b1}} :
			bond_sum[BOND_W-1:0];
		zero_sat = (zero_sum > SUM_W'({ZERO_W{1'b1}})) ? {ZERO_W{1'b1}} :
			zero_sum[ZERO_W-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			pair_valid      <= pair_ok_s2;
			bond_count      <= bond_sat;
			zero_spin_count <= zero_sat;
		end
	end

endmodule

@@ rtl/potts_row_pair_bond_counter_core.sv @@
// ----------------------------------------------------------------------------
// potts_row_pair_bond_counter_core: Potts row-pair bond counter
// Scores one pair of packed spin rows per item: range check, equal-neighbor
// bond count and zero-spin count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries row_now and row_next, each a
//   64-bit word of packed spin fields. Output channel (out_valid / out_stall)
//   returns pair_valid, bond_count and zero_spin_count, one result per item.
//   Configuration is a write-only port (cfg_write, cfg_index, cfg_data);
//   write it only while no item is in flight.
//   The input register takes the item at the accepting edge; the item then
//   moves on through the per-site compare register and the result register,
//   which drives out_valid.
//   Throughput is one item per cycle; the three registers advance together
//   whenever the result register is empty or being taken.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped.
//   Reset clears all valid flags and loads site_count 16, state_count 2,
//   cyclic_rows 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module potts_row_pair_bond_counter_core #(
	parameter int SITES_MAX      = 16,
	parameter int FIELD_BITS_MAX = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_write,
	input  logic [rpb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rpb_pkg::ROW_BITS-1:0]    row_now,
	input  logic [rpb_pkg::ROW_BITS-1:0]    row_next,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            pair_valid,
	output logic [rpb_pkg::BOND_W-1:0]      bond_count,
	output logic [rpb_pkg::ZERO_W-1:0]      zero_spin_count
);
	import rpb_pkg::*;

	cfg_t                 cfg;
	logic                 adv;
	logic                 valid_s2;
	logic                 pair_ok_s2;
	logic [SITES_MAX-1:0] horiz_eq_s2;
	logic [SITES_MAX-1:0] vert_eq_s2;
	logic [SITES_MAX-1:0] zero_s2;

	// pipeline advances unless a finished item is held by the receiver
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	rpb_cfg #(
		.SITES_MAX      (SITES_MAX),
		.FIELD_BITS_MAX (FIELD_BITS_MAX)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpb_site #(
		.SITES_MAX      (SITES_MAX),
		.FIELD_BITS_MAX (FIELD_BITS_MAX)
	) u_site (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.row_now     (row_now),
		.row_next    (row_next),
		.cfg         (cfg),
		.valid_s2    (valid_s2),
		.pair_ok_s2  (pair_ok_s2),
		.horiz_eq_s2 (horiz_eq_s2),
		.vert_eq_s2  (vert_eq_s2),
		.zero_s2     (zero_s2)
	);

	rpb_count #(
		.SITES_MAX (SITES_MAX)
	) u_count (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.valid_s2        (valid_s2),
		.pair_ok_s2      (pair_ok_s2),
		.horiz_eq_s2     (horiz_eq_s2),
		.vert_eq_s2      (vert_eq_s2),
		.zero_s2         (zero_s2),
		.out_valid       (out_valid),
		.pair_valid      (pair_valid),
		.bond_count      (bond_count),
		.zero_spin_count (zero_spin_count)
	);

endmodule
